@@ hdl/sar_pkg.sv @@
package sar_pkg;

  localparam int unsigned DefRows = 1024;
  localparam int unsigned DefCols = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] REG_LEARN_RATE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_B1_POWER   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_B2_POWER   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BETA_ONE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BETA_TWO   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_EPSILON    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ROWS_USED  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_ROW_WIDTH  = 3'd7;

  localparam logic [24:0] OneQ24 = 25'h100_0000;

  typedef enum logic [0:0] {
    CMD_APPLY = 1'b0,
    CMD_LOAD  = 1'b1
  } cmd_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic        load;
    logic        skip;
    logic [31:0] grad;
    logic [31:0] m_load;
    logic [30:0] v_load;
  } item_t;

  typedef struct packed {
    logic [31:0] p;
    logic [31:0] m;
    logic [30:0] v;
    logic        status;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_MOM,
    BK_ROOT,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_ROOT,
    SC_MUL,
    SC_DIV
  } scale_state_t;

endpackage

@@ hdl/sar_front.sv @@
module sar_front #(
  parameter int unsigned ROWS = sar_pkg::DefRows,
  parameter int unsigned COLS = sar_pkg::DefCols,
  parameter int unsigned AW   = $clog2(ROWS * COLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [9:0]         row,
  input  logic [3:0]         column,
  input  logic [31:0]        grad_value,
  input  logic [31:0]        first_moment_load,
  input  logic [30:0]        second_moment_load,
  input  logic [10:0]        rows_in_use,
  input  logic [4:0]         row_width,
  input  logic               busy,
  output logic               q_valid,
  input  logic               q_ready,
  output sar_pkg::item_t     q_item,
  output logic [AW-1:0]      q_addr
);

  localparam int unsigned Depth = 2;

  sar_pkg::item_t    fifo_item [Depth];
  logic [AW-1:0]     fifo_addr [Depth];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;
  logic              pop;
  logic              skip;
  sar_pkg::item_t    item;
  logic [AW-1:0]     addr;
  logic [31:0]       flat;

  always_comb begin
    skip = ({1'b0, row} >= rows_in_use) || (32'(row) >= 32'(ROWS)) ||
           ({1'b0, column} >= row_width) || (32'(column) >= 32'(COLS));
    flat = 32'(row) * 32'(COLS) + 32'(column);
    addr = flat[AW-1:0];
    item.load   = (cmd == sar_pkg::CMD_LOAD);
    item.skip   = skip;
    item.grad   = grad_value;
    item.m_load = first_moment_load;
    item.v_load = second_moment_load;
  end

  assign in_ready = (fill != 2'd2) && !busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = fifo_item[rd_ptr];
  assign q_addr   = fifo_addr[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_item[wr_ptr] <= item;
      fifo_addr[wr_ptr] <= addr;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hdl/sar_scale.sv @@
module sar_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] learn_rate,
  input  logic [23:0] beta_one_power,
  input  logic [23:0] beta_two_power,
  output logic [31:0] step_scale,
  output logic        busy
);

  sar_pkg::scale_state_t state, state_next;
  logic [49:0] rad;
  logic [49:0] rem;
  logic [24:0] root;
  logic [5:0]  cnt;
  logic [55:0] num;
  logic [24:0] div_d;
  logic [55:0] drem;
  logic [54:0] quo;
  logic [49:0] trial;
  logic [55:0] dtrial;

  // a new start restarts the computation from any state
  always_comb begin
    state_next = state;
    if (start) begin
      state_next = sar_pkg::SC_ROOT;
    end else begin
      unique case (state)
        sar_pkg::SC_IDLE: state_next = sar_pkg::SC_IDLE;
        sar_pkg::SC_ROOT: if (cnt == 6'd24) state_next = sar_pkg::SC_MUL;
        sar_pkg::SC_MUL:  state_next = sar_pkg::SC_DIV;
        sar_pkg::SC_DIV:  if (cnt == 6'd55) state_next = sar_pkg::SC_IDLE;
        default:          state_next = sar_pkg::SC_IDLE;
      endcase
    end
  end

  always_comb begin
    busy   = (state != sar_pkg::SC_IDLE) || start;
    trial  = {rem[47:0], rad[49:48]} - {23'd0, root, 2'b01};
    dtrial = {drem[54:0], num[55]} - {31'd0, div_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sar_pkg::SC_ROOT;
      cnt        <= 6'd0;
      rad        <= {1'b0, sar_pkg::OneQ24 - 25'd16760438, 24'd0};
      rem        <= '0;
      root       <= '0;
      div_d      <= 25'(sar_pkg::OneQ24) - 25'd15099494;
      step_scale <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        cnt   <= 6'd0;
        rad   <= {1'b0, sar_pkg::OneQ24 - {1'b0, beta_two_power}, 24'd0};
        rem   <= '0;
        root  <= '0;
        div_d <= sar_pkg::OneQ24 - {1'b0, beta_one_power};
      end else begin
        unique case (state)
          sar_pkg::SC_IDLE: ;
          sar_pkg::SC_ROOT: begin
            rad <= {rad[47:0], 2'b00};
            if (!trial[49]) begin
              rem  <= trial;
              root <= {root[23:0], 1'b1};
            end else begin
              rem  <= {rem[47:0], rad[49:48]};
              root <= {root[23:0], 1'b0};
            end
            cnt <= (cnt == 6'd24) ? 6'd0 : cnt + 6'd1;
          end
          sar_pkg::SC_MUL: begin
            num  <= 56'(learn_rate * root);
            drem <= '0;
            quo  <= '0;
          end
          sar_pkg::SC_DIV: begin
            num <= {num[54:0], 1'b0};
            if (!dtrial[55]) begin
              drem <= dtrial;
              quo  <= {quo[53:0], 1'b1};
            end else begin
              drem <= {drem[54:0], num[55]};
              quo  <= {quo[53:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd55) begin
              if (!dtrial[55]) step_scale <= (|quo[54:31]) ? '1 : {quo[30:0], 1'b1};
              else step_scale <= (|quo[54:31]) ? '1 : {quo[30:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hdl/sar_back.sv @@
module sar_back #(
  parameter int unsigned AW = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  sar_pkg::item_t  q_item,
  input  logic [AW-1:0]   q_addr,
  input  logic [24:0]     beta_one,
  input  logic [24:0]     beta_two,
  input  logic [24:0]     epsilon_term,
  input  logic [31:0]     step_scale,
  output logic            out_valid,
  input  logic            out_ready,
  output sar_pkg::result_t out_res
);

  localparam int unsigned Depth = 1 << AW;

  logic [31:0] p_mem [Depth];
  logic [31:0] m_mem [Depth];
  logic [30:0] v_mem [Depth];

  sar_pkg::back_state_t state, state_next;
  sar_pkg::item_t cur;
  sar_pkg::result_t acc;
  logic [AW-1:0]  addr;
  logic [31:0]    p_rd, m_rd;
  logic [30:0]    v_rd;
  logic [24:0]    omb1, omb2;
  logic signed [63:0] m_new, v_new, g2, p_new;
  logic [31:0]    m_sat;
  logic [30:0]    v_sat;
  logic [31:0]    p_sat;
  logic [31:0]    p_fin;
  logic [31:0]    gabs;
  logic [55:0]    rad;
  logic [55:0]    rem;
  logic [27:0]    root;
  logic [5:0]     cnt;
  logic [55:0]    trial;
  logic [31:0]    mag;
  logic [63:0]    num;
  logic [28:0]    den;
  logic [63:0]    drem;
  logic [63:0]    quo;
  logic [64:0]    dtrial;
  logic [40:0]    qcap;
  logic           wr_en;

  // combinational next state
  always_comb begin
    state_next = state;
    unique case (state)
      sar_pkg::BK_IDLE: if (q_valid) state_next = sar_pkg::BK_READ;
      sar_pkg::BK_READ:
        state_next = (cur.load || cur.skip) ? sar_pkg::BK_DONE : sar_pkg::BK_MOM;
      sar_pkg::BK_MOM:  state_next = sar_pkg::BK_ROOT;
      sar_pkg::BK_ROOT: if (cnt == 6'd27) state_next = sar_pkg::BK_MUL;
      sar_pkg::BK_MUL:  state_next = sar_pkg::BK_DIV;
      sar_pkg::BK_DIV:  if (cnt == 6'd63) state_next = sar_pkg::BK_DONE;
      sar_pkg::BK_DONE: if (!out_valid || out_ready) state_next = sar_pkg::BK_IDLE;
      default:          state_next = sar_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == sar_pkg::BK_IDLE);
    omb1 = (beta_one > sar_pkg::OneQ24) ? 25'd0 : sar_pkg::OneQ24 - beta_one;
    omb2 = (beta_two > sar_pkg::OneQ24) ? 25'd0 : sar_pkg::OneQ24 - beta_two;
    gabs = cur.grad[31] ? 32'(-cur.grad) : cur.grad;
    mag  = cur.m_load[31] ? 32'(-cur.m_load) : cur.m_load;
    // m + floor((g-m)*(1-b1)/2^24), arithmetic shift floors
    m_new = $signed({{32{m_rd[31]}}, m_rd}) +
            (((($signed({{32{cur.grad[31]}}, cur.grad}) -
               $signed({{32{m_rd[31]}}, m_rd})) * $signed({39'd0, omb1}))) >>> 24);
    v_new = $signed({33'd0, v_rd}) +
            (((g2 - $signed({33'd0, v_rd})) * $signed({39'd0, omb2})) >>> 24);
    if (m_new > 64'sd2147483647) m_sat = 32'h7FFF_FFFF;
    else if (m_new < -64'sd2147483648) m_sat = 32'h8000_0000;
    else m_sat = m_new[31:0];
    if (v_new > 64'sd2147483647) v_sat = 31'h7FFF_FFFF;
    else if (v_new < 64'sd0) v_sat = '0;
    else v_sat = v_new[30:0];
    trial  = {rem[53:0], rad[55:54]} - {26'd0, root, 2'b01};
    dtrial = {drem, num[63]} - {36'd0, den};
    qcap   = (quo > 64'h100_0000_0000) ? 41'h100_0000_0000 : quo[40:0];
    p_new  = cur.m_load[31] ? $signed({{32{p_rd[31]}}, p_rd}) + $signed({23'd0, qcap})
                            : $signed({{32{p_rd[31]}}, p_rd}) - $signed({23'd0, qcap});
    if (p_new > 64'sd2147483647) p_sat = 32'h7FFF_FFFF;
    else if (p_new < -64'sd2147483648) p_sat = 32'h8000_0000;
    else p_sat = p_new[31:0];
    p_fin = (cur.skip || cur.load) ? acc.p : p_sat;
    wr_en = (state == sar_pkg::BK_DONE) && !cur.skip && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (state == sar_pkg::BK_IDLE && q_valid) begin
      p_rd <= p_mem[q_addr];
      m_rd <= m_mem[q_addr];
      v_rd <= v_mem[q_addr];
    end
    if (wr_en) begin
      p_mem[addr] <= p_fin;
      m_mem[addr] <= acc.m;
      v_mem[addr] <= acc.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sar_pkg::BK_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        sar_pkg::BK_IDLE: if (q_valid) begin
          cur  <= q_item;
          addr <= q_addr;
        end
        sar_pkg::BK_READ: begin
          g2 <= $signed({32'd0, gabs} * {32'd0, gabs}) >>> 24;
          if (cur.skip) acc <= '{p: '0, m: '0, v: '0, status: 1'b1};
          else if (cur.load)
            acc <= '{p: cur.grad, m: cur.m_load, v: cur.v_load, status: 1'b0};
        end
        sar_pkg::BK_MOM: begin
          acc.m      <= m_sat;
          acc.v      <= v_sat;
          acc.status <= 1'b0;
          cur.m_load <= m_sat;
          rad  <= {1'b0, v_sat, 24'd0};
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
        end
        sar_pkg::BK_ROOT: begin
          rad <= {rad[53:0], 2'b00};
          if (!trial[55]) begin
            rem  <= trial;
            root <= {root[26:0], 1'b1};
          end else begin
            rem  <= {rem[53:0], rad[55:54]};
            root <= {root[26:0], 1'b0};
          end
          cnt <= (cnt == 6'd27) ? 6'd0 : cnt + 6'd1;
        end
        sar_pkg::BK_MUL: begin
          num  <= {32'd0, mag} * {32'd0, step_scale};
          den  <= (({1'b0, root} + {4'd0, epsilon_term}) == 29'd0) ? 29'd1
                  : {1'b0, root} + {4'd0, epsilon_term};
          drem <= '0;
          quo  <= '0;
          cnt  <= '0;
        end
        sar_pkg::BK_DIV: begin
          num <= {num[62:0], 1'b0};
          if (!dtrial[64]) begin
            drem <= dtrial[63:0];
            quo  <= {quo[62:0], 1'b1};
          end else begin
            drem <= {drem[62:0], num[63]};
            quo  <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
        end
        sar_pkg::BK_DONE: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_res   <= '{p: p_fin, m: acc.m, v: acc.v, status: acc.status};
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/sparse_adam_row_update.sv @@
// sparse adam row update: one transaction in, one result out. a load writes
// p, m and v of one element; an apply runs a lazy adam step on it. skipped
// (out of range) items return status 1 and zeros. an apply runs a 28-step
// bit serial square root and a 64-step restoring divider in the back end;
// loads and skips bypass both. after reset and after every register write
// the step scale is recomputed, during which no transaction is accepted.
// tables are not cleared.
module sparse_adam_row_update #(
  parameter int unsigned ROWS = sar_pkg::DefRows,
  parameter int unsigned COLS = sar_pkg::DefCols
) (
  input  logic         clk,
  input  logic         rst,
  // config write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic         s_tuser,    // cmd
  // row[9:0], column[13:10], grad_value[45:14], first_moment_load[77:46],
  // second_moment_load[108:78], zero fill to 112
  input  logic [111:0] s_tdata,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic         m_tuser,    // status
  // param_out[31:0], first_moment_out[63:32], second_moment_out[94:64], zero pad
  output logic [95:0]  m_tdata
);

  localparam int unsigned AW = $clog2(ROWS * COLS);

  logic [30:0] learn_rate;
  logic [23:0] beta_one_power, beta_two_power;
  logic [24:0] beta_one, beta_two, epsilon_term;
  logic [10:0] rows_in_use;
  logic [4:0]  row_width;
  logic        cfg_hit;
  logic [31:0] step_scale;
  logic        scale_busy;
  logic        q_valid, q_ready;
  sar_pkg::item_t   q_item;
  logic [AW-1:0]    q_addr;
  sar_pkg::result_t res;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate     <= 31'd16777;
      beta_one_power <= 24'd15099494;
      beta_two_power <= 24'd16760438;
      beta_one       <= 25'd15099494;
      beta_two       <= 25'd16760438;
      epsilon_term   <= 25'd17;
      rows_in_use    <= 11'd1024;
      row_width      <= 5'd1;
      cfg_hit        <= 1'b0;
    end else begin
      cfg_hit <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          sar_pkg::REG_LEARN_RATE: learn_rate     <= cfg_data;
          sar_pkg::REG_B1_POWER:   beta_one_power <= cfg_data[23:0];
          sar_pkg::REG_B2_POWER:   beta_two_power <= cfg_data[23:0];
          sar_pkg::REG_BETA_ONE:   beta_one       <= cfg_data[24:0];
          sar_pkg::REG_BETA_TWO:   beta_two       <= cfg_data[24:0];
          sar_pkg::REG_EPSILON:    epsilon_term   <= cfg_data[24:0];
          sar_pkg::REG_ROWS_USED:  rows_in_use    <= cfg_data[10:0];
          sar_pkg::REG_ROW_WIDTH:  row_width      <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  // a write during a running recompute restarts it with the new values
  sar_scale u_scale (
    .clk, .rst,
    .start(cfg_hit),
    .learn_rate, .beta_one_power, .beta_two_power,
    .step_scale, .busy(scale_busy)
  );

  sar_front #(.ROWS(ROWS), .COLS(COLS), .AW(AW)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .cmd(s_tuser),
    .row(s_tdata[9:0]), .column(s_tdata[13:10]),
    .grad_value(s_tdata[45:14]), .first_moment_load(s_tdata[77:46]),
    .second_moment_load(s_tdata[108:78]),
    .rows_in_use, .row_width,
    .busy(scale_busy || cfg_we),
    .q_valid, .q_ready, .q_item, .q_addr
  );

  sar_back #(.AW(AW)) u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_item, .q_addr,
    .beta_one, .beta_two, .epsilon_term, .step_scale,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_res(res)
  );

  assign m_tuser = res.status;
  assign m_tdata = {1'b0, res.v, res.m, res.p};

endmodule
